// ===== hdl/irig_b_frame_decoder_core_defines.svh =====
// ----------------------------------------------------------------------------
// IRIG-B frame decoder assertion macros
// Shared property wrappers; clocked on clk, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef IRIG_B_FRAME_DECODER_CORE_DEFINES_SVH
`define IRIG_B_FRAME_DECODER_CORE_DEFINES_SVH

// same-cycle implication
`define IRIGB_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define IRIGB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/irigb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IRIG-B frame decoder package
// Shared types, frame geometry and BCD weight tables.
// ----------------------------------------------------------------------------
package irigb_pkg;

    localparam int FRAME_LEN = 100;
    localparam int POS_W     = $clog2(FRAME_LEN);

    localparam logic [7:0] ZERO_BELOW_RST  = 8'd3;
    localparam logic [7:0] ONE_BELOW_RST   = 8'd6;
    localparam logic [7:0] MARKER_FROM_RST = 8'd7;
    localparam logic [7:0] MARKER_UPTO_RST = 8'd12;

    typedef enum logic [1:0] {
        SYM_ZERO = 2'd0,
        SYM_ONE  = 2'd1,
        SYM_MARK = 2'd2,
        SYM_NONE = 2'd3
    } sym_t;

    typedef enum logic [1:0] {
        REG_ZERO_BELOW  = 2'd0,
        REG_ONE_BELOW   = 2'd1,
        REG_MARKER_FROM = 2'd2,
        REG_MARKER_UPTO = 2'd3
    } cfg_reg_t;

    typedef enum logic [2:0] {
        FLD_NONE,
        FLD_SEC,
        FLD_MIN,
        FLD_HOUR,
        FLD_DAY,
        FLD_YEAR
    } field_t;

    typedef enum logic [1:0] {
        SC_IDLE,
        SC_RUN,
        SC_DRAIN,
        SC_DONE
    } scan_state_t;

    typedef enum logic {
        TS_IDLE,
        TS_SCAN
    } top_state_t;

    typedef struct packed {
        field_t     field;
        logic [7:0] value;
    } weight_t;

    typedef struct packed {
        logic             en;
        logic [POS_W-1:0] addr;
    } rd_req_t;

    typedef struct packed {
        logic             en;
        logic [POS_W-1:0] addr;
        sym_t             sym;
    } wr_req_t;

    typedef struct packed {
        logic       frame_ok;
        logic [7:0] sec;
        logic [7:0] min;
        logic [7:0] hour;
        logic [8:0] day;
        logic [7:0] year;
    } result_t;

    localparam logic [7:0] BCD2_W [9] = '{
        8'd1, 8'd2, 8'd4, 8'd8, 8'd0, 8'd10, 8'd20, 8'd40, 8'd80
    };

    localparam logic [7:0] BCD3_W [14] = '{
        8'd1, 8'd2, 8'd4, 8'd8, 8'd0, 8'd10, 8'd20, 8'd40, 8'd80,
        8'd0, 8'd100, 8'd200, 8'd0, 8'd0
    };

    // Field and weight that a one bit at a frame position contributes.
    function automatic weight_t pos_weight(input logic [POS_W-1:0] pos);
        weight_t          w;
        logic [POS_W-1:0] off;
        w.field = FLD_NONE;
        w.value = 8'd0;
        off     = '0;
        if (pos >= POS_W'(1) && pos <= POS_W'(9)) begin
            off     = pos - POS_W'(1);
            w.field = FLD_SEC;
            w.value = BCD2_W[off[3:0]];
        end else if (pos >= POS_W'(10) && pos <= POS_W'(18)) begin
            off     = pos - POS_W'(10);
            w.field = FLD_MIN;
            w.value = BCD2_W[off[3:0]];
        end else if (pos >= POS_W'(20) && pos <= POS_W'(28)) begin
            off     = pos - POS_W'(20);
            w.field = FLD_HOUR;
            w.value = BCD2_W[off[3:0]];
        end else if (pos >= POS_W'(30) && pos <= POS_W'(43)) begin
            off     = pos - POS_W'(30);
            w.field = FLD_DAY;
            w.value = BCD3_W[off[3:0]];
        end else if (pos >= POS_W'(50) && pos <= POS_W'(58)) begin
            off     = pos - POS_W'(50);
            w.field = FLD_YEAR;
            w.value = BCD2_W[off[3:0]];
        end
        return w;
    endfunction

endpackage

// ===== hdl/irigb_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IRIG-B symbol store
// One-entry-per-position symbol memory, one write and one registered read
// port. Entries never written since reset read back as zero symbols.
// ----------------------------------------------------------------------------
module irigb_store
    import irigb_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  wr_req_t wr,
    input  rd_req_t rd,
    output sym_t    rd_sym
);

    logic [1:0]           mem [FRAME_LEN];
    logic [FRAME_LEN-1:0] vld_reg;
    logic [1:0]           rd_data_reg;
    logic                 rd_vld_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.sym;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (wr.en)
        begin
            vld_reg[wr.addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            rd_data_reg <= mem[rd.addr];
            rd_vld_reg  <= vld_reg[rd.addr];
        end
    end

    assign rd_sym = rd_vld_reg ? sym_t'(rd_data_reg) : SYM_ZERO;

endmodule

// ===== hdl/irigb_scan.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IRIG-B frame scanner
// Walks the stored frame one position per cycle, checks the position
// markers and accumulates the BCD-weighted time fields.
// ----------------------------------------------------------------------------
module irigb_scan
    import irigb_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  logic    ack,
    output rd_req_t rd,
    input  sym_t    rd_sym,
    output logic    done,
    output result_t result
);

    scan_state_t      state_reg, state_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [3:0]       digit_reg, digit_next;
    logic             tag_vld_reg, tag_vld_next;
    logic [POS_W-1:0] tag_pos_reg, tag_pos_next;
    logic             tag_chk_reg, tag_chk_next;
    logic             ok_reg, ok_next;
    logic [7:0]       sec_reg, sec_next;
    logic [7:0]       min_reg, min_next;
    logic [7:0]       hour_reg, hour_next;
    logic [8:0]       day_reg, day_next;
    logic [7:0]       year_reg, year_next;
    weight_t          wt;
    logic             add_one;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= SC_IDLE;
            tag_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            tag_vld_reg <= tag_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg     <= pos_next;
        digit_reg   <= digit_next;
        tag_pos_reg <= tag_pos_next;
        tag_chk_reg <= tag_chk_next;
        ok_reg      <= ok_next;
        sec_reg     <= sec_next;
        min_reg     <= min_next;
        hour_reg    <= hour_next;
        day_reg     <= day_next;
        year_reg    <= year_next;
    end

    assign wt      = pos_weight(tag_pos_reg);
    assign add_one = tag_vld_reg && (rd_sym == SYM_ONE);

    always_comb
    begin
        state_next   = state_reg;
        pos_next     = pos_reg;
        digit_next   = digit_reg;
        tag_vld_next = 1'b0;
        tag_pos_next = tag_pos_reg;
        tag_chk_next = tag_chk_reg;
        ok_next      = ok_reg;
        sec_next     = sec_reg;
        min_next     = min_reg;
        hour_next    = hour_reg;
        day_next     = day_reg;
        year_next    = year_reg;
        rd.en        = 1'b0;
        rd.addr      = pos_reg;

        // data from the read issued last cycle
        if (tag_vld_reg && tag_chk_reg && rd_sym != SYM_MARK)
        begin
            ok_next = 1'b0;
        end
        if (add_one)
        begin
            case (wt.field)
                FLD_SEC:  sec_next  = sec_reg + wt.value;
                FLD_MIN:  min_next  = min_reg + wt.value;
                FLD_HOUR: hour_next = hour_reg + wt.value;
                FLD_DAY:  day_next  = day_reg + {1'b0, wt.value};
                FLD_YEAR: year_next = year_reg + wt.value;
                default:  ;
            endcase
        end

        case (state_reg)
            SC_IDLE:
            begin
                if (start)
                begin
                    pos_next   = '0;
                    digit_next = 4'd0;
                    ok_next    = 1'b1;
                    sec_next   = 8'd0;
                    min_next   = 8'd0;
                    hour_next  = 8'd0;
                    day_next   = 9'd0;
                    year_next  = 8'd0;
                    state_next = SC_RUN;
                end
            end
            SC_RUN:
            begin
                rd.en        = 1'b1;
                tag_vld_next = 1'b1;
                tag_pos_next = pos_reg;
                // markers sit at position 0 and every position ending in 9
                tag_chk_next = (pos_reg == '0) || (digit_reg == 4'd9);
                pos_next     = pos_reg + POS_W'(1);
                digit_next   = (digit_reg == 4'd9) ? 4'd0 : digit_reg + 4'd1;
                if (pos_reg == POS_W'(FRAME_LEN - 1))
                begin
                    state_next = SC_DRAIN;
                end
            end
            SC_DRAIN:
            begin
                state_next = SC_DONE;
            end
            SC_DONE:
            begin
                if (ack)
                begin
                    state_next = SC_IDLE;
                end
            end
            default:
            begin
                state_next = SC_IDLE;
            end
        endcase
    end

    assign done            = (state_reg == SC_DONE);
    assign result.frame_ok = ok_reg;
    assign result.sec      = sec_reg;
    assign result.min      = min_reg;
    assign result.hour     = hour_reg;
    assign result.day      = day_reg + 9'd1;
    assign result.year     = year_reg;

endmodule

// ===== hdl/irig_b_frame_decoder_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IRIG-B frame decoder core
// Classifies pulse widths into symbols, captures frames between double
// markers and reports the decoded time of each completed frame.
// ----------------------------------------------------------------------------
// Input channel: in_valid / in_stall carry one pulse width (ms) per item.
// Output channel: out_valid / out_stall carry one decoded frame per item,
// produced only when a double marker closes a captured frame.
// Config: cfg_we writes cfg_data[7:0] to threshold register cfg_index.
// Write only while the block is idle; the block itself does not enforce it.
// Items that do not close a frame are taken without stalling. An item that
// closes a frame starts a walk over the symbol memory, one position per
// cycle through its single read port, and the result is loaded into the
// output register when the walk is done and that register is free.
// in_stall is high for that whole walk.
// Reset clears the capture state; the symbol store reads as all zero
// symbols via per-entry valid bits, so no clearing pass is needed.
// A stalled output holds its item; a finished walk waits for the output
// register to free up, and the input stays stalled meanwhile.
// ----------------------------------------------------------------------------
`include "irig_b_frame_decoder_core_defines.svh"

module irig_b_frame_decoder_core
    import irigb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] pulse_width_ms,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       frame_valid,
    output logic [7:0] seconds,
    output logic [7:0] minutes,
    output logic [7:0] hours,
    output logic [8:0] day_number,
    output logic [7:0] year_digits
);

    logic [7:0]       zero_below_reg, one_below_reg, marker_from_reg, marker_upto_reg;
    top_state_t       state_reg, state_next;
    logic [POS_W-1:0] wp_reg, wp_next;
    sym_t             last_reg, last_next;
    logic             cap_reg, cap_next;
    logic             out_valid_reg, out_valid_next;
    result_t          res_reg;

    sym_t             sym;
    logic             keep;
    logic             accept;
    logic             dbl;
    logic             scan_start;
    logic             scan_done;
    logic             res_load;
    logic [POS_W-1:0] wp_eff;
    wr_req_t          wr;
    rd_req_t          rd;
    sym_t             rd_sym;
    result_t          scan_res;

    irigb_store u_store (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr     (wr),
        .rd     (rd),
        .rd_sym (rd_sym)
    );

    irigb_scan u_scan (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (scan_start),
        .ack    (res_load),
        .rd     (rd),
        .rd_sym (rd_sym),
        .done   (scan_done),
        .result (scan_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zero_below_reg  <= ZERO_BELOW_RST;
            one_below_reg   <= ONE_BELOW_RST;
            marker_from_reg <= MARKER_FROM_RST;
            marker_upto_reg <= MARKER_UPTO_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_ZERO_BELOW:  zero_below_reg  <= cfg_data;
                REG_ONE_BELOW:   one_below_reg   <= cfg_data;
                REG_MARKER_FROM: marker_from_reg <= cfg_data;
                REG_MARKER_UPTO: marker_upto_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    // marker test overrides the zero/one tests, even with crossed thresholds
    always_comb
    begin
        if (pulse_width_ms < zero_below_reg)
        begin
            sym = SYM_ZERO;
        end
        else if (pulse_width_ms < one_below_reg)
        begin
            sym = SYM_ONE;
        end
        else
        begin
            sym = SYM_NONE;
        end
        if (pulse_width_ms >= marker_from_reg)
        begin
            sym = SYM_MARK;
        end
    end

    assign keep     = (sym != SYM_NONE) && (pulse_width_ms <= marker_upto_reg);
    assign in_stall = (state_reg != TS_IDLE);
    assign accept   = in_valid && !in_stall;
    assign dbl      = (sym == SYM_MARK) && (last_reg == SYM_MARK);
    assign wp_eff   = dbl ? '0 : wp_reg;
    assign res_load = scan_done && (!out_valid_reg || !out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= TS_IDLE;
            wp_reg        <= '0;
            last_reg      <= SYM_ZERO;
            cap_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wp_reg        <= wp_next;
            last_reg      <= last_next;
            cap_reg       <= cap_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            res_reg <= scan_res;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        wp_next        = wp_reg;
        last_next      = last_reg;
        cap_next       = cap_reg;
        scan_start     = 1'b0;
        wr.en          = 1'b0;
        wr.addr        = wp_eff;
        wr.sym         = sym;
        out_valid_next = out_valid_reg && out_stall;
        if (res_load)
        begin
            out_valid_next = 1'b1;
        end

        case (state_reg)
            TS_IDLE:
            begin
                if (accept && keep)
                begin
                    last_next = sym;
                    if (dbl && cap_reg)
                    begin
                        // decode first; the closing marker is stored afterwards
                        scan_start = 1'b1;
                        state_next = TS_SCAN;
                    end
                    else if (dbl || cap_reg)
                    begin
                        cap_next = 1'b1;
                        wr.en    = 1'b1;
                        wp_next  = (wp_eff == POS_W'(FRAME_LEN - 1)) ? '0
                                                                      : wp_eff + POS_W'(1);
                    end
                end
            end
            TS_SCAN:
            begin
                if (res_load)
                begin
                    wr.en      = 1'b1;
                    wr.addr    = '0;
                    wr.sym     = SYM_MARK;
                    wp_next    = POS_W'(1);
                    state_next = TS_IDLE;
                end
            end
            default:
            begin
                state_next = TS_IDLE;
            end
        endcase
    end

    assign out_valid   = out_valid_reg;
    assign frame_valid = res_reg.frame_ok;
    assign seconds     = res_reg.sec;
    assign minutes     = res_reg.min;
    assign hours       = res_reg.hour;
    assign day_number  = res_reg.day;
    assign year_digits = res_reg.year;

    `IRIGB_ASSERT_NOW(a_wp_range, 1'b1, wp_reg < POS_W'(FRAME_LEN), "write position out of range")
    `IRIGB_ASSERT_NOW(a_start_capt, scan_start, cap_reg && last_reg == SYM_MARK, "scan without capture")
    `IRIGB_ASSERT_NEXT(a_load_out, res_load, out_valid && state_reg == TS_IDLE, "result not presented")
    `IRIGB_ASSERT_NOW(a_scan_wr, state_reg == TS_SCAN && wr.en, res_load, "store write during scan")

endmodule

// ===== tb/irig_b_frame_decoder_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IRIG-B frame decoder core testbench
// Feeds pulse widths through the valid/stall input and predicts every decoded
// frame in a tracker class that mirrors the symbol store and the thresholds.
// Decoded frames are checked field by field. The run has a short directed part
// and then randomized frames (full, long, short, noisy) under several
// threshold settings and idling patterns.
// ----------------------------------------------------------------------------
module irig_b_frame_decoder_core_tb;
    import irigb_pkg::*;

    localparam int HALF_PERIOD    = 5;
    localparam int RESET_CYCLES   = 5;
    localparam int DRAIN_CYCLES   = 120;
    localparam int CYCLE_LIMIT    = 2000000;
    localparam int PHASE_ITEMS    = 160;
    localparam int NUM_PHASES     = 8;

    // BCD weights; the two-digit fields use the first nine
    localparam int unsigned DIGIT_WEIGHT [14] = '{
        1, 2, 4, 8, 0, 10, 20, 40, 80, 0, 100, 200, 0, 0
    };

    // zero_below, one_below, marker_from, marker_upto per phase
    localparam logic [7:0] THRESHOLD_SET [8][4] = '{
        '{8'd3,   8'd6,   8'd7,   8'd12},
        '{8'd20,  8'd60,  8'd100, 8'd255},
        '{8'd1,   8'd2,   8'd2,   8'd9},
        '{8'd5,   8'd200, 8'd100, 8'd150},   // markers override ones
        '{8'd0,   8'd50,  8'd60,  8'd80},    // no zero width exists
        '{8'd128, 8'd255, 8'd255, 8'd255},
        '{8'd10,  8'd5,   8'd30,  8'd40},    // no one width exists
        '{8'd3,   8'd6,   8'd7,   8'd12}
    };

    typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;
    typedef enum {FILL_RANDOM, FILL_ONES, FILL_ZEROS} fill_t;

    typedef struct packed {
        logic       markers_ok;
        logic [7:0] sec;
        logic [7:0] minute;
        logic [7:0] hour;
        logic [8:0] day;
        logic [7:0] year;
    } decoded_frame_t;

    class irig_frame_tracker;
        sym_t           store [FRAME_LEN];
        int unsigned    wr_pos;
        sym_t           last_sym;
        bit             capturing;
        logic [7:0]     thr [4];
        decoded_frame_t due_frames [$];
        int unsigned    errors;
        int unsigned    frames_seen;

        function new();
            foreach (store[i])
                store[i] = SYM_ZERO;
            wr_pos      = 0;
            last_sym    = SYM_ZERO;
            capturing   = 1'b0;
            thr[REG_ZERO_BELOW]  = 8'd3;
            thr[REG_ONE_BELOW]   = 8'd6;
            thr[REG_MARKER_FROM] = 8'd7;
            thr[REG_MARKER_UPTO] = 8'd12;
            errors      = 0;
            frames_seen = 0;
        endfunction

        function void set_threshold(cfg_reg_t r, logic [7:0] v);
            thr[r] = v;
        endfunction

        function sym_t classify(logic [7:0] w);
            sym_t s;
            s = SYM_NONE;
            if (w < thr[REG_ZERO_BELOW])
                s = SYM_ZERO;
            else if (w < thr[REG_ONE_BELOW])
                s = SYM_ONE;
            if (w >= thr[REG_MARKER_FROM])
                s = SYM_MARK;
            if (w > thr[REG_MARKER_UPTO])
                s = SYM_NONE;
            return s;
        endfunction

        function int unsigned bcd_sum(int unsigned first, int unsigned n);
            int unsigned sum;
            sum = 0;
            for (int unsigned k = 0; k < n; k++)
            begin
                if (first + k < FRAME_LEN && store[first + k] == SYM_ONE)
                    sum += DIGIT_WEIGHT[k];
            end
            return sum;
        endfunction

        function bit markers_in_place();
            if (store[0] != SYM_MARK)
                return 1'b0;
            for (int i = 9; i < FRAME_LEN; i += 10)
            begin
                if (store[i] != SYM_MARK)
                    return 1'b0;
            end
            return 1'b1;
        endfunction

        function void note_pulse(logic [7:0] w);
            sym_t           s;
            decoded_frame_t f;
            s = classify(w);
            if (s == SYM_NONE)
                return;
            if (s == SYM_MARK && last_sym == SYM_MARK)
            begin
                // decode happens before the new marker lands at index 0
                if (capturing)
                begin
                    f.markers_ok = markers_in_place();
                    f.sec        = 8'(bcd_sum(1, 9));
                    f.minute     = 8'(bcd_sum(10, 9));
                    f.hour       = 8'(bcd_sum(20, 9));
                    f.day        = 9'(bcd_sum(30, 14) + 1);
                    f.year       = 8'(bcd_sum(50, 9));
                    due_frames.push_back(f);
                end
                capturing = 1'b1;
                wr_pos    = 0;
            end
            last_sym = s;
            if (capturing)
            begin
                store[wr_pos] = s;
                wr_pos++;
                if (wr_pos >= FRAME_LEN)
                    wr_pos = 0;
            end
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got)
            begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_frame(decoded_frame_t got);
            decoded_frame_t want;
            frames_seen++;
            if (due_frames.size() == 0)
            begin
                $error("decoded frame with none expected: frame_valid %0d seconds %0d",
                       got.markers_ok, got.sec);
                errors++;
                return;
            end
            want = due_frames.pop_front();
            compare_field("frame_valid", want.markers_ok, got.markers_ok);
            compare_field("seconds", want.sec, got.sec);
            compare_field("minutes", want.minute, got.minute);
            compare_field("hours", want.hour, got.hour);
            compare_field("day_number", want.day, got.day);
            compare_field("year_digits", want.year, got.year);
        endfunction

        function int unsigned pending();
            return due_frames.size();
        endfunction
    endclass

    logic       clk            = 1'b0;
    logic       rst_n          = 1'b0;
    logic       cfg_we         = 1'b0;
    logic [1:0] cfg_index      = REG_ZERO_BELOW;
    logic [7:0] cfg_data       = 8'd0;
    logic       in_valid       = 1'b0;
    logic       in_stall;
    logic [7:0] pulse_width_ms = 8'd0;
    logic       out_valid;
    logic       out_stall      = 1'b0;
    logic       frame_valid;
    logic [7:0] seconds;
    logic [7:0] minutes;
    logic [7:0] hours;
    logic [8:0] day_number;
    logic [7:0] year_digits;

    irig_frame_tracker tracker = new();
    int unsigned       gap_pct    = 0;
    int unsigned       stall_pct  = 0;
    int unsigned       items_sent = 0;
    int unsigned       cycles_run = 0;

    irig_b_frame_decoder_core i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .pulse_width_ms (pulse_width_ms),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .frame_valid    (frame_valid),
        .seconds        (seconds),
        .minutes        (minutes),
        .hours          (hours),
        .day_number     (day_number),
        .year_digits    (year_digits)
    );

    always #HALF_PERIOD clk = ~clk;

    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        decoded_frame_t got;
        if (rst_n && out_valid && !out_stall)
        begin
            got.markers_ok = frame_valid;
            got.sec        = seconds;
            got.minute     = minutes;
            got.hour       = hours;
            got.day        = day_number;
            got.year       = year_digits;
            tracker.check_frame(got);
        end
    end

    always @(posedge clk)
    begin
        cycles_run++;
        if (cycles_run >= CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic send_pulse(input logic [7:0] w);
        @(negedge clk);
        while ($urandom_range(99) < gap_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid       <= 1'b1;
        pulse_width_ms <= w;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (tracker.classify(w) != SYM_NONE)
            items_sent++;
        tracker.note_pulse(w);
    endtask

    // Random width of the wanted class under the current thresholds; falls back
    // to any width when the class cannot occur.
    function automatic logic [7:0] width_for(sym_t want);
        logic [7:0] w;
        logic [7:0] start;
        for (int k = 0; k < 8; k++)
        begin
            w = 8'($urandom_range(255));
            if (tracker.classify(w) == want)
                return w;
        end
        start = 8'($urandom_range(255));
        for (int k = 0; k < 256; k++)
        begin
            w = start + 8'(k);
            if (tracker.classify(w) == want)
                return w;
        end
        return start;
    endfunction

    task automatic send_symbol(input sym_t s);
        send_pulse(width_for(s));
    endtask

    // Drop valid, wait for every decoded frame and let the walk finish.
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t r, input logic [7:0] v);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= r;
        cfg_data  <= v;
        @(posedge clk);
        tracker.set_threshold(r, v);
    endtask

    task automatic write_thresholds(input logic [7:0] z, o, mf, mu);
        write_reg(REG_ZERO_BELOW, z);
        write_reg(REG_ONE_BELOW, o);
        write_reg(REG_MARKER_FROM, mf);
        write_reg(REG_MARKER_UPTO, mu);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_idling(input idle_mode_t mode);
        case (mode)
            IDLE_NONE:     begin gap_pct = 0;  stall_pct = 0;  end
            IDLE_SENDER:   begin gap_pct = 69; stall_pct = 0;  end
            IDLE_RECEIVER: begin gap_pct = 0;  stall_pct = 69; end
            default:       begin gap_pct = 7;  stall_pct = 7;  end
        endcase
    endtask

    // Marker at index 0 closes the previous frame, then positions 1..len-1.
    // Markers sit at 9, 19, ... and at the last position, never two adjacent.
    task automatic send_frame(input int unsigned len, input fill_t fill, input bit noisy);
        sym_t s;
        send_symbol(SYM_MARK);
        for (int unsigned pos = 1; pos < len; pos++)
        begin
            if (pos == len - 1 || (pos % 10 == 9 && pos != len - 2))
                s = SYM_MARK;
            else if (fill == FILL_ONES)
                s = SYM_ONE;
            else if (fill == FILL_ZEROS)
                s = SYM_ZERO;
            else
                s = $urandom_range(1) ? SYM_ONE : SYM_ZERO;
            if (noisy)
            begin
                if ($urandom_range(9) == 0)
                    send_pulse(8'($urandom_range(255)));
                if ($urandom_range(9) == 0)
                    send_symbol(SYM_NONE);
                // knock out a position marker now and then
                if (s == SYM_MARK && pos != len - 1 && $urandom_range(3) == 0)
                    s = SYM_ZERO;
            end
            send_symbol(s);
        end
    endtask

    task automatic run_phase(input int p);
        int unsigned first_item;
        int unsigned len;
        int unsigned pick;
        fill_t       fill;
        bit          paused;
        settle();
        write_thresholds(THRESHOLD_SET[p % 8][REG_ZERO_BELOW],
                         THRESHOLD_SET[p % 8][REG_ONE_BELOW],
                         THRESHOLD_SET[p % 8][REG_MARKER_FROM],
                         THRESHOLD_SET[p % 8][REG_MARKER_UPTO]);
        set_idling(idle_mode_t'(p % 4));
        first_item = items_sent;
        paused     = 1'b0;
        send_symbol(SYM_MARK);      // pairs with the first frame's marker
        while (items_sent - first_item < PHASE_ITEMS)
        begin
            pick = $urandom_range(99);
            if (pick < 40)
                len = FRAME_LEN;
            else if (pick < 55)
                len = $urandom_range(FRAME_LEN + 30, FRAME_LEN + 1);
            else
                len = $urandom_range(60, 2);
            pick = $urandom_range(99);
            fill = (pick < 60) ? FILL_RANDOM : (pick < 80) ? FILL_ONES : FILL_ZEROS;
            send_frame(len, fill, $urandom_range(4) == 0);
            // in odd phases the sender holds off once, halfway through, until every pending frame is out
            if ((p % 2) == 1 && !paused && items_sent - first_item >= PHASE_ITEMS / 2)
            begin
                settle();
                paused = 1'b1;
            end
        end
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        // reset thresholds: every class, dropped widths, double and triple markers
        send_pulse(8'd0);
        send_pulse(8'd2);
        send_pulse(8'd3);
        send_pulse(8'd5);
        send_pulse(8'd6);
        send_pulse(8'd13);
        send_pulse(8'd255);
        send_pulse(8'd7);
        send_pulse(8'd12);          // capture starts, nothing decoded
        send_pulse(8'd2);
        send_pulse(8'd3);
        send_pulse(8'd5);
        send_pulse(8'd7);
        send_pulse(8'd12);          // short frame over stale entries
        send_pulse(8'd7);
        send_pulse(8'd6);           // dropped, last symbol stays a marker
        send_pulse(8'd12);

        settle();
        write_thresholds(8'd0, 8'd0, 8'd0, 8'd0);
        send_pulse(8'd0);
        send_pulse(8'd0);
        send_pulse(8'd1);

        settle();
        write_thresholds(8'd255, 8'd255, 8'd255, 8'd255);
        send_pulse(8'd255);
        send_pulse(8'd255);
        send_pulse(8'd254);
        send_pulse(8'd0);

        for (int p = 0; p < NUM_PHASES; p++)
            run_phase(p);

        settle();
        if (tracker.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
